FILE: design/asac_pkg.sv
// Shared types and constants for the arcsine/arccosine to binary angle block.
// Used by asac_isqrt, asac_series and the top level; no dependencies.
package asac_pkg;

    localparam int unsigned RadWidth = 58;
    localparam int unsigned RootWidth = 29;
    localparam int unsigned SqStages = 29;
    localparam int unsigned XWidth = 29;
    localparam int unsigned PWidth = 31;
    localparam int unsigned Frac = 28;

    localparam logic [PWidth-1:0] OneQ28 = PWidth'(64'd268435456);
    localparam logic [PWidth-1:0] CoefC3 = PWidth'(64'd44739243);
    localparam logic [PWidth-1:0] CoefC5 = PWidth'(64'd20132659);
    localparam logic [PWidth-1:0] CoefC7 = PWidth'(64'd11983726);
    localparam logic [PWidth-1:0] CoefC9 = PWidth'(64'd8155591);
    localparam logic [63:0] ToAngleK = 64'd683565276;
    localparam logic [63:0] QuarterScaled = 64'd1 << 58;
    localparam logic [15:0] QuarterTurn = 16'h4000;
    localparam logic signed [15:0] UnitPos = 16'sd16384;
    localparam logic signed [15:0] UnitNeg = -16'sd16384;

    typedef enum logic
    {
        OP_ASIN = 1'b0,
        OP_ACOS = 1'b1
    } op_t;

    typedef struct packed
    {
        logic        neg;
        op_t         op;
        logic        refl;
        logic [14:0] mag;
    } side_t;

endpackage

FILE: design/asac_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on asac_pkg for widths and the side-band struct.
module asac_isqrt import asac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [RadWidth-1:0]  radicand,
    input  side_t                side_in,
    output logic                 out_vld,
    output logic [RootWidth-1:0] root,
    output side_t                side_out
);

    localparam int unsigned SqTop = 2 * (SqStages - 1);

    logic  [RadWidth-1:0] rem_reg  [SqStages];
    logic  [RadWidth-1:0] res_reg  [SqStages];
    side_t                side_reg [SqStages];
    logic                 vld_reg  [SqStages];

    genvar i;
    generate
        for (i = 0; i < SqStages; i++)
        begin : g_stage
            localparam logic [RadWidth-1:0] BitV = RadWidth'(1) << (SqTop - 2 * i);
            logic  [RadWidth-1:0] rem_prev;
            logic  [RadWidth-1:0] res_prev;
            logic  [RadWidth-1:0] trial;
            logic  [RadWidth-1:0] rem_next;
            logic  [RadWidth-1:0] res_next;
            side_t                side_prev;
            logic                 vld_prev;

            if (i == 0)
            begin : g_first
                assign rem_prev  = radicand;
                assign res_prev  = '0;
                assign side_prev = side_in;
                assign vld_prev  = in_vld;
            end
            else
            begin : g_rest
                assign rem_prev  = rem_reg[i-1];
                assign res_prev  = res_reg[i-1];
                assign side_prev = side_reg[i-1];
                assign vld_prev  = vld_reg[i-1];
            end

            always_comb
            begin
                trial = res_prev + BitV;
                if (rem_prev >= trial)
                begin
                    rem_next = rem_prev - trial;
                    res_next = (res_prev >> 1) + BitV;
                end
                else
                begin
                    rem_next = rem_prev;
                    res_next = res_prev >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= rem_next;
                    res_reg[i]  <= res_next;
                    side_reg[i] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[SqStages-1];
    assign root     = res_reg[SqStages-1][RootWidth-1:0];
    assign side_out = side_reg[SqStages-1];

endmodule

FILE: design/asac_series.sv
// Pipelined Horner evaluation of the arcsine series and radian-to-angle scaling.
// Depends on asac_pkg for coefficients, widths and the side-band struct.
module asac_series import asac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [XWidth-1:0] x,
    input  side_t             side_in,
    output logic              out_vld,
    output logic [63:0]       scaled,
    output side_t             side_out
);

    localparam int unsigned NSt = 7;

    logic              vld_reg  [NSt];
    side_t             side_reg [NSt];
    logic [XWidth-1:0] x_reg    [NSt];
    logic [XWidth-1:0] x2_reg   [NSt];
    logic [PWidth-1:0] p_reg    [NSt];
    logic [63:0]       prod_reg;

    logic [63:0] sq;
    logic [63:0] hp1;
    logic [63:0] hp2;
    logic [63:0] hp3;
    logic [63:0] hp4;
    logic [63:0] sx;
    logic [63:0] sk;

    assign sq  = 64'(x) * 64'(x);
    assign hp1 = 64'(CoefC9) * 64'(x2_reg[0]);
    assign hp2 = 64'(p_reg[1]) * 64'(x2_reg[1]);
    assign hp3 = 64'(p_reg[2]) * 64'(x2_reg[2]);
    assign hp4 = 64'(p_reg[3]) * 64'(x2_reg[3]);
    assign sx  = 64'(p_reg[4]) * 64'(x_reg[4]);
    assign sk  = 64'(p_reg[5]) * ToAngleK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSt; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < NSt; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            x_reg[0]    <= x;
            x2_reg[0]   <= XWidth'(sq >> Frac);
            p_reg[0]    <= '0;
            for (int k = 1; k < NSt; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                x_reg[k]    <= x_reg[k-1];
                x2_reg[k]   <= x2_reg[k-1];
            end
            p_reg[1] <= CoefC7 + PWidth'(hp1 >> Frac);
            p_reg[2] <= CoefC5 + PWidth'(hp2 >> Frac);
            p_reg[3] <= CoefC3 + PWidth'(hp3 >> Frac);
            p_reg[4] <= OneQ28 + PWidth'(hp4 >> Frac);
            p_reg[5] <= PWidth'(sx >> Frac);
            p_reg[6] <= '0;
            prod_reg <= sk;
        end
    end

    assign out_vld  = vld_reg[NSt-1];
    assign scaled   = prod_reg;
    assign side_out = side_reg[NSt-1];

endmodule

FILE: design/arcsine_arccosine_to_binary_angle.sv
// Top level: input conditioning, square root and series pipelines, output stage.
// Depends on asac_pkg, asac_isqrt and asac_series.
//
// Usage:
// - Input channel: value (signed Q2.14) and operation (0 arcsine, 1 arccosine),
//   qualified by in_valid; a transfer happens when in_valid is high and
//   in_stall is low.
// - Output channel: angle (16-bit binary angle, 0x4000 a quarter turn),
//   qualified by out_valid; a transfer happens when out_stall is low.
// - Throughput: one item per cycle while the pipeline is not held by out_stall.
// - Pipeline from input transfer to out_valid: one conditioning stage,
//   29 square-root stages (one root bit each), 7 series and scaling
//   stages (one multiplier each) and the output register.
// - Reset clears every valid bit; no result is pending afterwards.
// - When the receiver holds out_stall with a result pending, the whole
//   pipeline holds and in_stall rises; nothing is lost or repeated.
// - Inputs beyond +-1.0 saturate to +-1.0.
module arcsine_arccosine_to_binary_angle import asac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] value,
    input  logic               operation,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] angle
);

    logic en;

    logic signed [15:0]   sat;
    logic [14:0]          amag;
    logic [29:0]          asq;
    side_t                side_c;
    logic [RadWidth-1:0]  rad_c;

    logic                 c_vld_reg;
    side_t                c_side_reg;
    logic [RadWidth-1:0]  c_rad_reg;

    logic                 sq_vld;
    logic [RootWidth-1:0] sq_root;
    side_t                sq_side;
    logic [XWidth-1:0]    xsel;

    logic                 se_vld;
    logic [63:0]          se_scaled;
    side_t                se_side;

    logic [15:0]          mag_w;
    logic [15:0]          asin_w;
    logic [15:0]          angle_next;
    logic                 o_vld_reg;
    logic [15:0]          angle_reg;

    assign en       = !(o_vld_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        priority if (value > UnitPos)
            sat = UnitPos;
        else if (value < UnitNeg)
            sat = UnitNeg;
        else
            sat = value;
        amag        = sat[15] ? 15'(-sat) : 15'(sat);
        asq         = 30'(amag) * 30'(amag);
        side_c.neg  = sat[15];
        side_c.op   = op_t'(operation);
        side_c.refl = (31'(asq) << 1) >= 31'(64'd268435456);
        side_c.mag  = amag;
        rad_c       = RadWidth'(30'd268435456 - asq) << Frac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= side_c;
            c_rad_reg  <= rad_c;
        end
    end

    asac_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c_vld_reg),
        .radicand (c_rad_reg),
        .side_in  (c_side_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    assign xsel = sq_side.refl ? sq_root : (XWidth'(sq_side.mag) << 14);

    asac_series u_series
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld),
        .x        (xsel),
        .side_in  (sq_side),
        .out_vld  (se_vld),
        .scaled   (se_scaled),
        .side_out (se_side)
    );

    always_comb
    begin
        if (se_side.refl)
            mag_w = 16'((QuarterScaled - se_scaled) >> 44);
        else
            mag_w = 16'(se_scaled >> 44);
        asin_w = se_side.neg ? (16'd0 - mag_w) : mag_w;
        unique case (se_side.op)
            OP_ASIN: angle_next = asin_w;
            OP_ACOS: angle_next = QuarterTurn - asin_w;
            default: angle_next = asin_w;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            o_vld_reg <= se_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign angle     = angle_reg;

endmodule

FILE: sim/arcsine_arccosine_to_binary_angle_tb.sv
// Testbench for arcsine_arccosine_to_binary_angle: random and directed Q2.14 values,
// predicted angles checked in order by a small scoreboard class.
// Depends on asac_pkg and the block's RTL.
module arcsine_arccosine_to_binary_angle_tb;
    import asac_pkg::*;

    localparam longint unsigned CycleLimit = 400000;
    localparam int unsigned Latency = 38;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] value;
    logic operation;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] angle;

    int unsigned mismatches;
    longint unsigned cycles;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    class angle_scoreboard;
        logic [15:0] pending_angles[$];

        function logic [63:0] root_of(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic [63:0] taylor_sum(logic [63:0] x);
            logic [63:0] x2;
            logic [63:0] p;
            x2 = (x * x) >> 28;
            p = 64'(CoefC9);
            p = 64'(CoefC7) + ((p * x2) >> 28);
            p = 64'(CoefC5) + ((p * x2) >> 28);
            p = 64'(CoefC3) + ((p * x2) >> 28);
            p = 64'(OneQ28) + ((p * x2) >> 28);
            return (p * x) >> 28;
        endfunction

        function void note_input(logic signed [15:0] v, op_t op);
            int sv;
            logic [63:0] a;
            logic [63:0] mag;
            logic [15:0] asin_angle;
            sv = v;
            if (sv > 16384)
                sv = 16384;
            if (sv < -16384)
                sv = -16384;
            a = (sv < 0) ? 64'(-sv) : 64'(sv);
            if (a == 0)
                mag = 0;
            else if (2 * a * a < 64'd268435456)
                mag = (taylor_sum(a << 14) * ToAngleK) >> 44;
            else
                mag = (QuarterScaled - taylor_sum(root_of((64'd268435456 - a * a) << 28))
                    * ToAngleK) >> 44;
            asin_angle = (sv < 0) ? 16'(0 - mag) : 16'(mag);
            pending_angles.push_back(op == OP_ACOS ? QuarterTurn - asin_angle : asin_angle);
        endfunction

        task check_result(logic [15:0] got);
            logic [15:0] want;
            if (pending_angles.size() == 0)
            begin
                report_mismatch("angle with no pending input", got, 16'h0);
                return;
            end
            want = pending_angles.pop_front();
            if (got !== want)
                report_mismatch("angle", got, want);
        endtask
    endclass

    angle_scoreboard board;

    arcsine_arccosine_to_binary_angle u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .operation(operation),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .angle(angle)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("arcsine_arccosine_to_binary_angle verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(angle);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(logic signed [15:0] v, logic op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        operation <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(v, op_t'(op));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_angles.size() != 0)
            @(posedge clk);
        repeat (Latency + 4)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'($urandom);
        if (r < 3)
            return 16'(16'($urandom_range(11606, 11566)) * (($urandom_range(1)) ? 1 : -1));
        if (r == 3)
            return 16'(16'($urandom_range(16384, 16300)) * (($urandom_range(1)) ? 1 : -1));
        return 16'($urandom_range(32768) - 16384);
    endfunction

    initial
    begin
        logic signed [15:0] edge_vals[] = '{16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384,
            16'sd11585, 16'sd11586, -16'sd11585, -16'sd11586, 16'sh7fff, 16'sh8000,
            16'sd16385, -16'sd16385};
        board = new();
        mismatches = 0;
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = 16'sd0;
        operation = 1'b0;
        out_stall = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (edge_vals[i])
        begin
            send_item(edge_vals[i], 1'b0);
            send_item(edge_vals[i], 1'b1);
        end
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 45 : (ph == 3) ? 34 : 0;
            stall_pct = (ph == 2) ? 45 : (ph == 3) ? 34 : 0;
            if (ph == 0)
                hold_cycles = 120;
            for (int n = 0; n < 340; n++)
                send_item(pick_value(), 1'($urandom));
            drain();
        end
        if (board.pending_angles.size() == 0 && mismatches == 0)
            $display("arcsine_arccosine_to_binary_angle verification clean");
        else
            $display("arcsine_arccosine_to_binary_angle verification failed");
        $finish;
    end
endmodule

FILE: sim.f
design/asac_pkg.sv
design/asac_isqrt.sv
design/asac_series.sv
design/arcsine_arccosine_to_binary_angle.sv
sim/arcsine_arccosine_to_binary_angle_tb.sv
